FILE: hdl/bslf_pkg.sv
// ----------------------------------------------------------------------------
// bslf_pkg
// shared types, constants and codes for the bit set with lazy flip and count
// ----------------------------------------------------------------------------
package bslf_pkg;

   localparam int MAX_BITS    = 1024;
   localparam int WORD_BITS   = 32;
   localparam int WORD_COUNT  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int POS_W       = 10;
   localparam int COUNT_W     = 11;
   localparam int ACTION_W    = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // action codes
   localparam logic [ACTION_W-1:0] ACT_SET   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLIP  = 2'd2;

   // register index, taken from the word address bit of paddr
   localparam logic CSR_IDX_BIT_COUNT = 1'b0;

   localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = COUNT_W'(MAX_BITS);
   localparam logic [COUNT_W-1:0] BIT_COUNT_MAX   = COUNT_W'(MAX_BITS);
   localparam logic [COUNT_W-1:0] BIT_COUNT_MIN   = COUNT_W'(1);

   // classified work for the back end
   typedef enum logic [2:0] {
      OP_NONE,
      OP_SET,
      OP_CLEAR,
      OP_FLIP,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [POS_W-1:0]    position;
   } req_payload_type;

   typedef struct packed {
      logic               all_set;
      logic               any_set;
      logic [COUNT_W-1:0] ones_total;
      logic               bad_position;
   } rsp_payload_type;

   typedef struct packed {
      op_type                op;
      logic [WORD_IDX_W-1:0] word_idx;
      logic [BIT_IDX_W-1:0]  bit_idx;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/bslf_front.sv
// ----------------------------------------------------------------------------
// bslf_front
// classifies an incoming transaction into a work entry for the back end
// ----------------------------------------------------------------------------
module bslf_front (
   input  bslf_pkg::req_payload_type        req_payload,
   input  logic [bslf_pkg::COUNT_W-1:0]     n_eff,
   output bslf_pkg::work_type               work
);
   import bslf_pkg::*;

   logic out_of_range;

   assign out_of_range = {1'b0, req_payload.position} >= n_eff;

   always_comb begin
      work.word_idx = req_payload.position[POS_W-1:BIT_IDX_W];
      work.bit_idx  = req_payload.position[BIT_IDX_W-1:0];
      case (req_payload.action)
         ACT_SET: begin
            work.op = out_of_range ? OP_BAD : OP_SET;
         end
         ACT_CLEAR: begin
            work.op = out_of_range ? OP_BAD : OP_CLEAR;
         end
         ACT_FLIP: begin
            work.op = OP_FLIP;
         end
         default: begin
            work.op = OP_NONE;
         end
      endcase
   end

endmodule

FILE: hdl/bslf_queue.sv
// ----------------------------------------------------------------------------
// bslf_queue
// two-entry queue decoupling the front end from the back end
// ----------------------------------------------------------------------------
module bslf_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  bslf_pkg::work_type           push_data,
   input  logic                         pop,
   output bslf_pkg::work_type           pop_data,
   output bslf_pkg::queue_status_type   status
);
   import bslf_pkg::*;

   work_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff;
   logic [QCNT_W-1:0] cnt_in;

   always_comb begin
      status.full  = cnt_ff == QCNT_W'(QUEUE_DEPTH);
      status.empty = cnt_ff == '0;
      pop_data     = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/bslf_back.sv
// ----------------------------------------------------------------------------
// bslf_back
// word read-modify-write, invert flag, ones count and result register
// ----------------------------------------------------------------------------
module bslf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear_store,
   input  logic [bslf_pkg::COUNT_W-1:0] n_eff,
   input  logic                         head_valid,
   input  bslf_pkg::work_type           head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bslf_pkg::rsp_payload_type    rsp_payload
);
   import bslf_pkg::*;

   logic [WORD_BITS-1:0] words_ff [WORD_COUNT];
   logic [WORD_COUNT-1:0] word_vld_ff;
   logic                  inv_ff;
   logic                  inv_in;
   logic [COUNT_W-1:0]    ones_ff;
   logic [COUNT_W-1:0]    ones_in;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;
   rsp_payload_type       rsp_payload_in;

   logic [WORD_BITS-1:0]  word_rd;
   logic [WORD_BITS-1:0]  bit_mask;
   logic                  logical;
   logic                  word_wr;

   always_comb begin
      pop      = head_valid && (!rsp_valid_ff || rsp_ready);
      // words never written since the last clear read as zero
      word_rd  = word_vld_ff[head.word_idx] ? words_ff[head.word_idx] : '0;
      bit_mask = WORD_BITS'(1) << head.bit_idx;
      logical  = ((word_rd & bit_mask) != '0) ^ inv_ff;

      inv_in  = inv_ff;
      ones_in = ones_ff;
      word_wr = 1'b0;
      case (head.op)
         OP_SET: begin
            if (!logical) begin
               word_wr = 1'b1;
               ones_in = ones_ff + 1'b1;
            end
         end
         OP_CLEAR: begin
            if (logical) begin
               word_wr = 1'b1;
               ones_in = ones_ff - 1'b1;
            end
         end
         OP_FLIP: begin
            inv_in  = ~inv_ff;
            ones_in = (ones_ff <= n_eff) ? n_eff - ones_ff : '0;
         end
         default: begin
         end
      endcase

      rsp_payload_in.all_set      = ones_in == n_eff;
      rsp_payload_in.any_set      = ones_in != '0;
      rsp_payload_in.ones_total   = ones_in;
      rsp_payload_in.bad_position = head.op == OP_BAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_vld_ff  <= '0;
         inv_ff       <= 1'b0;
         ones_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clear_store) begin
            word_vld_ff <= '0;
            inv_ff      <= 1'b0;
            ones_ff     <= '0;
         end else if (pop) begin
            inv_ff  <= inv_in;
            ones_ff <= ones_in;
            if (word_wr) begin
               word_vld_ff[head.word_idx] <= 1'b1;
            end
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && word_wr && !clear_store) begin
         words_ff[head.word_idx] <= word_rd ^ bit_mask;
      end
      if (pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: hdl/bitset_lazy_flip_counter.sv
// an accepted transaction is registered in the queue and then in the result register before its result shows
// throughput: one transaction per cycle unless results stall; set by the single word read-modify-write in back end
// the bit store is a flip-flop word array with one valid bit per word, so no clearing pass
// reset: synchronous, active high; store, invert flag, count and queue cleared at once
// reset leaves bit_count at 1024; a bit_count write clears the store in the same cycle
// ----------------------------------------------------------------------------
// bitset_lazy_flip_counter
// bit set with lazy inversion and running ones count, front/queue/back split
// ----------------------------------------------------------------------------
module bitset_lazy_flip_counter (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bslf_pkg::req_payload_type       req_payload,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bslf_pkg::rsp_payload_type       rsp_payload,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bslf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bslf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bslf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import bslf_pkg::*;

   // bit_count register and its saturated form
   logic [COUNT_W-1:0] bit_count_ff;
   logic [COUNT_W-1:0] bit_count_in;
   logic [COUNT_W-1:0] n_eff;
   logic               csr_write;
   logic               bit_count_write;

   // front to queue to back
   work_type           front_work;
   work_type           head_work;
   queue_status_type   q_status;
   logic               req_accept;
   logic               back_pop;

   // register port: always ready, register index from the word address bit
   assign pready          = 1'b1;
   assign csr_write       = psel && penable && pwrite && pready;
   assign bit_count_write = csr_write && (paddr[2] == CSR_IDX_BIT_COUNT);

   always_comb begin
      bit_count_in = bit_count_ff;
      if (bit_count_write) begin
         bit_count_in = pwdata[COUNT_W-1:0];
      end
      prdata = '0;
      if (paddr[2] == CSR_IDX_BIT_COUNT) begin
         prdata = CSR_DATA_W'(bit_count_ff);
      end
      // sizes outside one to the store size are clamped
      if (bit_count_ff < BIT_COUNT_MIN) begin
         n_eff = BIT_COUNT_MIN;
      end else if (bit_count_ff > BIT_COUNT_MAX) begin
         n_eff = BIT_COUNT_MAX;
      end else begin
         n_eff = bit_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= BIT_COUNT_RESET;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   // front end: range check and action decode, one transaction per cycle while the queue is not full
   assign req_ready  = !q_status.full;
   assign req_accept = req_valid && req_ready;

   bslf_front u_front (
      .req_payload (req_payload),
      .n_eff       (n_eff),
      .work        (front_work)
   );

   // short queue that holds up to two requests while the result side stalls; once full it blocks new requests
   bslf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_work),
      .pop       (back_pop),
      .pop_data  (head_work),
      .status    (q_status)
   );

   // back end: word update, invert flag, count and result register
   bslf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clear_store (bit_count_write),
      .n_eff       (n_eff),
      .head_valid  (!q_status.empty),
      .head        (head_work),
      .pop         (back_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // queue status is never full and empty together
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty");

   // no result is offered in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // a transaction into an empty pipe shows its result once it has passed the queue and the result register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && q_status.empty && !rsp_valid) |-> ##2 rsp_valid)
      else $error("result missing after an idle-pipe transaction");

   // the back end only takes work when there is some
   assert property (@(posedge clock) disable iff (reset)
      back_pop |-> !q_status.empty)
      else $error("pop from an empty queue");
`endif

endmodule
